/* rtl/core/sync_length_checksum_deframer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length/checksum deframer
// Shared overlapping-implication and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define SLCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define SLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the deframer front end, queue and replay back end.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int SUM_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

    localparam logic [BYTE_W-1:0] START_RESET = 8'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_CK_FAIL  = 2'd1,
        ST_EMPTY_OK = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CKHI,
        PH_CKLO,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_bstate;

    // one queued job: either a single status item or a payload replay
    typedef struct packed {
        logic             replay;
        t_status          status;
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // back end hands a buffer bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

/* rtl/core/slcd_queue.sv */
// ----------------------------------------------------------------------------
// slcd_queue
// Small register FIFO carrying jobs from the front end to the back end.
// ----------------------------------------------------------------------------
module slcd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slcd_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output slcd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import slcd_pkg::*;

    t_cmd              r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= QPTR_W'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= QPTR_W'(r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= (QPTR_W+1)'(r_cnt + 1'b1);
            end else if (!i_push && i_pop) begin
                r_cnt <= (QPTR_W+1)'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/core/slcd_front.sv */
// ----------------------------------------------------------------------------
// slcd_front
// Frame parser: start hunt, length, checksum, payload capture and verdict.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_unit_macros.svh"

module slcd_front #(
    parameter int  MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF,
    localparam int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slcd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                              o_wr_en,
    output logic [AW:0]                       o_wr_addr,
    output logic [slcd_pkg::BYTE_W-1:0]       o_wr_data,
    output logic                              o_push,
    output slcd_pkg::t_cmd                    o_cmd,
    input  logic                              i_q_full,
    input  slcd_pkg::t_rel                    i_rel
);
    import slcd_pkg::*;

    localparam logic [LEN_W-1:0] MAXP = LEN_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] r_start;
    logic [LEN_W-1:0]  r_max_len;
    t_phase            r_phase, n_phase;
    logic [1:0]        r_busy,  n_busy;
    logic              r_bank,  n_bank;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [LEN_W-1:0]  r_rem,   n_rem;
    logic [SUM_W-1:0]  r_exp,   n_exp;
    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [AW-1:0]     r_widx,  n_widx;

    logic [LEN_W-1:0]  limit;
    logic [SUM_W-1:0]  sum_add;
    logic              accept;

    assign limit   = (r_max_len > MAXP) ? MAXP : r_max_len;
    assign sum_add = SUM_W'(r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_data_byte});
    assign o_ready = !i_q_full && !(r_phase == PH_DATA && r_busy[r_bank]);
    assign accept  = i_valid && o_ready;

    assign o_wr_addr = {r_bank, r_widx};
    assign o_wr_data = i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= START_RESET;
            r_max_len <= MAXP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_BYTE: r_start   <= i_cfg_data;
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_busy  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_rem  <= n_rem;
        r_exp  <= n_exp;
        r_sum  <= n_sum;
        r_widx <= n_widx;
    end

    always_comb begin
        n_phase = r_phase;
        n_bank  = r_bank;
        n_len   = r_len;
        n_rem   = r_rem;
        n_exp   = r_exp;
        n_sum   = r_sum;
        n_widx  = r_widx;
        o_wr_en = 1'b0;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_data_byte == r_start) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = i_data_byte[LEN_W-1:0];
                    if ({1'b0, limit} < i_data_byte) begin
                        o_push        = 1'b1;
                        o_cmd.status  = ST_TOO_LONG;
                        n_phase       = PH_HUNT;
                    end else begin
                        n_phase = PH_CKHI;
                    end
                end
                PH_CKHI: begin
                    n_exp   = {i_data_byte, {BYTE_W{1'b0}}};
                    n_phase = PH_CKLO;
                end
                PH_CKLO: begin
                    n_exp  = {r_exp[SUM_W-1:BYTE_W], i_data_byte};
                    n_sum  = '0;
                    n_widx = '0;
                    n_rem  = r_len;
                    if (r_len == '0) begin
                        o_push       = 1'b1;
                        o_cmd.status = ({r_exp[SUM_W-1:BYTE_W], i_data_byte} == '0) ?
                                       ST_EMPTY_OK : ST_CK_FAIL;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_wr_en = 1'b1;
                    n_widx  = AW'(r_widx + 1'b1);
                    n_sum   = sum_add;
                    n_rem   = LEN_W'(r_rem - 1'b1);
                    if (r_rem == LEN_W'(1)) begin
                        o_push  = 1'b1;
                        n_phase = PH_HUNT;
                        if (sum_add == r_exp) begin
                            o_cmd.replay = 1'b1;
                            o_cmd.status = ST_PAYLOAD;
                            o_cmd.bank   = r_bank;
                            o_cmd.len    = r_len;
                            n_bank       = ~r_bank;
                        end else begin
                            o_cmd.status = ST_CK_FAIL;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push && o_cmd.replay) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    `SLCD_ASSERT_NOW(a_data_bank_free, i_clk, i_rst_n,
        accept && r_phase == PH_DATA, !r_busy[r_bank], "payload written into busy bank")
    `SLCD_ASSERT_NOW(a_push_room, i_clk, i_rst_n,
        o_push, !i_q_full, "job pushed into full queue")
    `SLCD_ASSERT_NEXT(a_busy_set, i_clk, i_rst_n,
        o_push && o_cmd.replay, r_busy[$past(r_bank)] && r_bank != $past(r_bank),
        "replayed bank not held")

endmodule

/* rtl/core/slcd_back.sv */
// ----------------------------------------------------------------------------
// slcd_back
// Payload buffer and job executor: replays verified payloads, sends status items.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_unit_macros.svh"

module slcd_back #(
    parameter int  MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF,
    localparam int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [AW:0]                      i_wr_addr,
    input  logic [slcd_pkg::BYTE_W-1:0]      i_wr_data,
    input  logic                             i_q_valid,
    input  slcd_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output slcd_pkg::t_rel                   o_rel,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [slcd_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [slcd_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_last
);
    import slcd_pkg::*;

    logic [BYTE_W-1:0] r_mem [2**(AW+1)];
    logic [BYTE_W-1:0] r_rd_data;

    t_bstate           r_state, n_state;
    logic              r_bank,  n_bank;
    logic [LEN_W-1:0]  r_cnt,   n_cnt;
    logic [AW-1:0]     r_k,     n_k;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    t_status           r_out_status, n_out_status;
    logic              r_out_last,  n_out_last;

    logic              out_free;
    logic              rd_en;
    logic              load;

    assign out_free   = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[{r_bank, r_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank       <= n_bank;
        r_cnt        <= n_cnt;
        r_k          <= n_k;
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        o_rel        = '0;
        rd_en        = 1'b0;
        load         = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.replay) begin
                        o_pop   = 1'b1;
                        n_bank  = i_cmd.bank;
                        n_cnt   = i_cmd.len;
                        n_k     = '0;
                        n_state = BK_READ;
                    end else if (out_free) begin
                        o_pop        = 1'b1;
                        load         = 1'b1;
                        n_out_byte   = '0;
                        n_out_status = i_cmd.status;
                        n_out_last   = 1'b1;
                    end
                end
            end
            BK_READ: begin
                rd_en   = 1'b1;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_byte   = r_rd_data;
                    n_out_status = ST_PAYLOAD;
                    n_out_last   = (r_cnt == LEN_W'(1));
                    if (r_cnt == LEN_W'(1)) begin
                        o_rel.valid = 1'b1;
                        o_rel.bank  = r_bank;
                        n_state     = BK_IDLE;
                    end else begin
                        n_cnt   = LEN_W'(r_cnt - 1'b1);
                        n_k     = AW'(r_k + 1'b1);
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    `SLCD_ASSERT_NOW(a_status_zero, i_clk, i_rst_n,
        r_out_valid && r_out_status != ST_PAYLOAD, r_out_byte == '0 && r_out_last,
        "status item with data or without last")
    `SLCD_ASSERT_NEXT(a_release_last, i_clk, i_rst_n,
        o_rel.valid, r_out_valid && r_out_last && r_out_status == ST_PAYLOAD,
        "bank released before final payload item")
    `SLCD_ASSERT_NOW(a_emit_after_read, i_clk, i_rst_n,
        r_state == BK_EMIT, $past(r_state) == BK_READ || $past(r_state) == BK_EMIT,
        "emit without buffer read")

endmodule

/* rtl/core/sync_length_checksum_deframer_unit.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Start-byte / length / 16-bit additive checksum packet deframer.
// ----------------------------------------------------------------------------
// Bytes enter one item per cycle into the parser, which hunts for the start
// byte, reads the length and big-endian checksum, and writes the payload into
// one of two buffer banks while summing it. Its verdict goes through a
// two-entry job queue to the back end, which sends one status item, or
// replays a verified payload, loading each buffer read into the output
// register before the next read. Input stalls only while that queue is full
// or the bank it would write is still being replayed. The buffer needs no
// clearing pass; the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [slcd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [slcd_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [slcd_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_last
);
    import slcd_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              wr_en;
    logic [AW:0]       wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              push;
    t_cmd              push_cmd;
    logic              q_full;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              pop;
    t_rel              rel;

    slcd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_full    (q_full),
        .i_rel       (rel)
    );

    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    slcd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_q_valid  (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_rel      (rel),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

/* dv/slcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_checker
// Watches the byte input, the config port and the result channel of the
// deframer. Every accepted byte is run through a local deframer model; the
// results it yields are queued and compared field by field against the
// items the block delivers.
// ----------------------------------------------------------------------------
module slcd_checker #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [slcd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]   i_out_byte,
    input  logic [slcd_pkg::STATUS_W-1:0] i_out_status,
    input  logic                          i_out_last,
    output int                            o_fail_count,
    output int                            o_pending
);
    import slcd_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_status           status;
        logic              last;
    } t_deframed;

    t_deframed deframed_q[$];

    logic [BYTE_W-1:0] cfg_start;
    logic [LEN_W-1:0]  cfg_max;

    t_phase            parse_phase;
    logic [7:0]        bytes_left;
    logic [7:0]        frame_len;
    logic [SUM_W-1:0]  want_sum;
    logic [SUM_W-1:0]  got_sum;
    logic [LEN_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] frame_buf [MAX_PAYLOAD];

    int fail_count = 0;

    task automatic report(input string what, input int expv, input int gotv);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t deframer mismatch: %s expected %0h got %0h",
                     $time, what, expv, gotv);
    endtask

    task automatic queue_item(input logic [BYTE_W-1:0] b, input t_status st,
                              input logic lst);
        t_deframed it;
        it.data   = b;
        it.status = st;
        it.last   = lst;
        deframed_q.push_back(it);
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        int limit;
        int k;
        limit = (cfg_max > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_max);
        case (parse_phase)
            PH_HUNT: begin
                if (b == cfg_start)
                    parse_phase = PH_LEN;
            end
            PH_LEN: begin
                frame_len = b;
                if (int'(b) > limit) begin
                    queue_item('0, ST_TOO_LONG, 1'b1);
                    parse_phase = PH_HUNT;
                end else begin
                    parse_phase = PH_CKHI;
                end
            end
            PH_CKHI: begin
                want_sum    = {b, 8'h00};
                parse_phase = PH_CKLO;
            end
            PH_CKLO: begin
                want_sum[7:0] = b;
                got_sum       = '0;
                wr_idx        = '0;
                bytes_left    = frame_len;
                if (frame_len == 0) begin
                    queue_item('0, (want_sum == 0) ? ST_EMPTY_OK : ST_CK_FAIL, 1'b1);
                    parse_phase = PH_HUNT;
                end else begin
                    parse_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (wr_idx < MAX_PAYLOAD)
                    frame_buf[wr_idx] = b;
                wr_idx     = wr_idx + 1'b1;
                got_sum    = got_sum + b;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    if (got_sum == want_sum) begin
                        for (k = 0; k < frame_len && k < MAX_PAYLOAD; k++)
                            queue_item(frame_buf[k], ST_PAYLOAD, (k + 1) == frame_len);
                    end else begin
                        queue_item('0, ST_CK_FAIL, 1'b1);
                    end
                    parse_phase = PH_HUNT;
                end
            end
            default: parse_phase = PH_HUNT;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_start   = START_RESET;
            cfg_max     = LEN_W'(MAX_PAYLOAD);
            parse_phase = PH_HUNT;
            bytes_left  = '0;
            frame_len   = '0;
            want_sum    = '0;
            got_sum     = '0;
            wr_idx      = '0;
            deframed_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_BYTE)
                    cfg_start = i_cfg_data;
                else if (i_cfg_idx == CFG_MAX_LENGTH)
                    cfg_max = i_cfg_data[LEN_W-1:0];
            end
            if (i_in_valid && i_in_ready)
                deframe_byte(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                if (deframed_q.size() == 0) begin
                    report("unexpected item, byte", 0, i_out_byte);
                end else begin
                    t_deframed want;
                    want = deframed_q.pop_front();
                    if (i_out_byte !== want.data)
                        report("out_byte", want.data, i_out_byte);
                    if (i_out_status !== want.status)
                        report("status", want.status, i_out_status);
                    if (i_out_last !== want.last)
                        report("last", want.last, i_out_last);
                end
            end
        end
        o_pending    <= deframed_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sync/length/checksum deframer. Sends directed
// frames, then random streams of good, corrupted, oversized and truncated
// frames mixed with line noise, across several start byte / length limit
// settings, with random idling on both sides and back-pressure stretches.
// ----------------------------------------------------------------------------
module tb;
    import slcd_pkg::*;

    localparam int CFG_SETTLE = 16;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last;

    int fail_count;
    int pending;

    int rx_hold   = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    logic [BYTE_W-1:0] cur_start = START_RESET;
    int                cur_max   = MAX_PAYLOAD_DEF;

    logic [BYTE_W-1:0] directed_bytes [28] = '{
        8'h02, 8'h00, 8'h00, 8'h00,
        8'h02, 8'h00, 8'h80, 8'h01,
        8'h02, 8'd65,
        8'h02, 8'hFF,
        8'h02, 8'h01, 8'h00, 8'hFF, 8'hFF,
        8'h02, 8'h02, 8'h00, 8'h04, 8'h02, 8'h02,
        8'h02, 8'h01, 8'h00, 8'h00, 8'h05
    };

    sync_length_checksum_deframer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data_byte(i_data_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    slcd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_byte   (i_data_byte),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_byte  (o_out_byte),
        .i_out_status(o_status),
        .i_out_last  (o_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random idling, or a counted hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                i_ready <= rx_steady || ($urandom_range(99) >= 26);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!tx_steady) begin
            while ($urandom_range(99) < 26) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [BYTE_W-1:0] start, input int maxlen);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_BYTE;
        i_cfg_data <= start;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_LENGTH;
        i_cfg_data <= CFG_W'(maxlen);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_start = start;
        cur_max   = maxlen;
    endtask

    task automatic send_frame(input int len, input bit corrupt, inout int sent);
        logic [BYTE_W-1:0] body [MAX_PAYLOAD_DEF];
        logic [SUM_W-1:0]  ck;
        int                k;
        ck = '0;
        for (k = 0; k < len; k++) begin
            body[k] = 8'($urandom_range(255));
            ck      = ck + body[k];
        end
        if (corrupt)
            ck = ck ^ SUM_W'($urandom_range(65535, 1));
        send_byte(cur_start);
        send_byte(len[7:0]);
        send_byte(ck[15:8]);
        send_byte(ck[7:0]);
        for (k = 0; k < len; k++)
            send_byte(body[k]);
        sent += 4 + len;
    endtask

    task automatic send_random_frames(input int budget, input bit drain_each);
        int sent;
        int pick;
        int len;
        int k;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                k = $urandom_range(99);
                if (k < 5)
                    len = cur_max;
                else if (k < 12)
                    len = $urandom_range(cur_max);
                else
                    len = $urandom_range((cur_max < 8) ? cur_max : 8);
                send_frame(len, $urandom_range(99) < 15, sent);
            end else if (pick < 80) begin
                send_byte(cur_start);
                send_byte(8'($urandom_range(255, cur_max + 1)));
                sent += 2;
            end else if (pick < 90) begin
                len = $urandom_range(4, 1);
                repeat (len) send_byte(8'($urandom_range(255)));
                sent += len;
            end else begin
                send_byte(cur_start);
                len = $urandom_range(6);
                repeat (len + 1) send_byte(8'($urandom_range(255)));
                sent += len + 2;
            end
            if (drain_each)
                wait_drained();
        end
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 28; k++)
            send_byte(directed_bytes[k]);

        // receiver holds off while frames keep coming
        write_cfg(8'hFF, MAX_PAYLOAD_DEF);
        rx_hold <= 400;
        send_random_frames(110, 1'b0);

        write_cfg(8'h00, 0);
        send_random_frames(60, 1'b0);

        write_cfg(8'($urandom_range(255)), 1);
        send_random_frames(60, 1'b1);

        write_cfg(8'($urandom_range(255)), $urandom_range(63, 2));
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_random_frames(110, 1'b0);

        write_cfg(START_RESET, MAX_PAYLOAD_DEF);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        send_random_frames(110, 1'b0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sync_length_checksum_deframer_unit.f */
+incdir+rtl/core
rtl/core/slcd_pkg.sv
rtl/core/slcd_queue.sv
rtl/core/slcd_front.sv
rtl/core/slcd_back.sv
rtl/core/sync_length_checksum_deframer_unit.sv
dv/slcd_checker.sv
dv/tb.sv
